>>> sv/pcanon_pkg.sv
package pcanon_pkg;

  localparam int MAX_LEN_DEF   = 256;
  localparam int MAX_DEPTH_DEF = 64;

  localparam int BYTE_W   = 8;
  localparam int RLEN_W   = 9;
  localparam int DEPTH_W  = 7;
  localparam int MODE_W   = 2;

  localparam logic [BYTE_W-1:0] DOT_BYTE  = 8'd46;
  localparam logic [BYTE_W-1:0] SEP_RESET = 8'd47;

  typedef enum logic [MODE_W-1:0] {
    MODE_BYTE = 2'd0,
    MODE_END  = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    RSEL_ZERO = 2'd0,
    RSEL_MEM  = 2'd1,
    RSEL_SEP  = 2'd2
  } rsel_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_op_t;

endpackage

>>> sv/pcanon_store.sv
module pcanon_store #(
  parameter int MAX_LEN = 256
) (
  input  logic                       clk,
  input  logic                       wa_en,
  input  logic [$clog2(MAX_LEN)-1:0] wa_addr,
  input  logic [7:0]                 wa_data,
  input  logic                       wb_en,
  input  logic [$clog2(MAX_LEN)-1:0] wb_addr,
  input  logic [7:0]                 wb_data,
  input  logic                       rd_en,
  input  logic [$clog2(MAX_LEN)-1:0] rd_addr,
  output logic [7:0]                 rd_data
);
  import pcanon_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int RW = AW - 1;
  localparam int BD = (MAX_LEN + 1) / 2;

  // two interleaved banks: a separator/byte pair always lands in both
  logic [BYTE_W-1:0] even_mem [BD];
  logic [BYTE_W-1:0] odd_mem  [BD];

  logic              even_we, odd_we;
  logic [RW-1:0]     even_row, odd_row;
  logic [BYTE_W-1:0] even_din, odd_din;
  logic [BYTE_W-1:0] even_q_r, odd_q_r;
  logic              odd_sel_r;
  logic              a_even, b_even;

  assign a_even = wa_en && !wa_addr[0];
  assign b_even = wb_en && !wb_addr[0];

  always_comb begin
    even_we  = a_even || b_even;
    even_row = a_even ? wa_addr[AW-1:1] : wb_addr[AW-1:1];
    even_din = a_even ? wa_data : wb_data;
    odd_we   = (wa_en && wa_addr[0]) || (wb_en && wb_addr[0]);
    odd_row  = (wa_en && wa_addr[0]) ? wa_addr[AW-1:1] : wb_addr[AW-1:1];
    odd_din  = (wa_en && wa_addr[0]) ? wa_data : wb_data;
  end

  always_ff @(posedge clk) begin
    if (even_we) begin
      even_mem[even_row] <= even_din;
    end
    if (odd_we) begin
      odd_mem[odd_row] <= odd_din;
    end
    if (rd_en) begin
      even_q_r  <= even_mem[rd_addr[AW-1:1]];
      odd_q_r   <= odd_mem[rd_addr[AW-1:1]];
      odd_sel_r <= rd_addr[0];
    end
  end

  assign rd_data = odd_sel_r ? odd_q_r : even_q_r;

endmodule

>>> sv/pcanon_stack.sv
module pcanon_stack #(
  parameter int MAX_DEPTH = 64,
  parameter int DW        = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pcanon_pkg::stk_op_t            op,
  input  logic [DW-1:0]                  push_data,
  output logic [$clog2(MAX_DEPTH+1)-1:0] count,
  output logic [DW-1:0]                  top
);
  import pcanon_pkg::*;

  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int SW = $clog2(MAX_DEPTH);

  // top entry lives in top_r; the memory holds the entries below it
  logic [DW-1:0] stk_mem [MAX_DEPTH];

  logic [CW-1:0] count_r, count_nxt;
  logic [DW-1:0] top_r, top_nxt;
  logic [DW-1:0] rd_q_r, fwd_data_r, below;
  logic          fwd_r;
  logic          wr_en;
  logic [SW-1:0] wr_addr, rd_addr;

  assign below   = fwd_r ? fwd_data_r : rd_q_r;
  assign wr_en   = op.push && (count_r != '0);
  assign wr_addr = SW'(count_r - CW'(1));
  assign rd_addr = SW'(count_nxt - CW'(2));

  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    if (op.clear) begin
      count_nxt = '0;
    end else if (op.push) begin
      count_nxt = count_r + CW'(1);
      top_nxt   = push_data;
    end else if (op.pop) begin
      count_nxt = count_r - CW'(1);
      top_nxt   = below;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    fwd_r      <= wr_en && (wr_addr == rd_addr);
    fwd_data_r <= top_r;
    rd_q_r     <= stk_mem[rd_addr];
    if (wr_en) begin
      stk_mem[wr_addr] <= top_r;
    end
  end

  assign count = count_r;
  assign top   = top_r;

endmodule

>>> sv/path_canonicalizer_unit.sv
// channel  | ports                                         | direction
// in       | in_valid in_stall in_mode in_data_byte in_read_index | request in
// out      | out_valid out_stall out_result_byte out_result_length
//          | out_kept_depth out_overflow                   | result out
// cfg      | cfg_wr_en cfg_wr_data                         | separator write
// One request per cycle while in_stall is low; each result passes through the stage-1
// registers, which take the registered path-store read, and then the output register.
// Stack pops see the entry below the top through a prefetched read with bypass.
// Synchronous active-low reset clears control; store contents stay undefined.
// out_stall backs up into in_stall only when both output stages are full.
module path_canonicalizer_unit #(
  parameter int MAX_LEN   = pcanon_pkg::MAX_LEN_DEF,
  parameter int MAX_DEPTH = pcanon_pkg::MAX_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pcanon_pkg::MODE_W-1:0]   in_mode,
  input  logic [pcanon_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic [pcanon_pkg::BYTE_W-1:0]   in_read_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pcanon_pkg::BYTE_W-1:0]   out_result_byte,
  output logic [pcanon_pkg::RLEN_W-1:0]   out_result_length,
  output logic [pcanon_pkg::DEPTH_W-1:0]  out_kept_depth,
  output logic                            out_overflow,
  input  logic                            cfg_wr_en,
  input  logic [pcanon_pkg::BYTE_W-1:0]   cfg_wr_data
);
  import pcanon_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int XW = (LW > BYTE_W) ? LW : BYTE_W;

  logic [BYTE_W-1:0] sep_r;
  logic [LW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     cstart_r, cstart_nxt;
  logic [1:0]        clen_r, clen_nxt;
  logic              dots_r, dots_nxt;
  logic              ovf_r, ovf_nxt;
  logic              fin_r, fin_nxt;
  logic [CW-1:0]     cnt, cnt_nxt;
  logic [AW-1:0]     stk_top;
  stk_op_t           op;

  logic              wa_en, wb_en, rd_en;
  logic [AW-1:0]     wa_addr, wb_addr, rd_addr;
  logic [BYTE_W-1:0] wa_data, wb_data, rd_data;

  logic              in_acc, adv1;
  logic              close_now, end_now;
  rsel_t             rsel;

  logic               v1_r;
  rsel_t              sel1_r;
  logic [BYTE_W-1:0]  sep1_r;
  logic [RLEN_W-1:0]  len1_r;
  logic [DEPTH_W-1:0] dep1_r;
  logic               ovf1_r;

  logic               out_valid_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [RLEN_W-1:0]  len_r;
  logic [DEPTH_W-1:0] dep_r;
  logic               oflag_r;

  assign adv1     = v1_r && (!out_valid_r || !out_stall);
  assign in_stall = v1_r && !adv1;
  assign in_acc   = in_valid && !in_stall;

  pcanon_store #(.MAX_LEN(MAX_LEN)) u_store (
    .clk     (clk),
    .wa_en   (wa_en),
    .wa_addr (wa_addr),
    .wa_data (wa_data),
    .wb_en   (wb_en),
    .wb_addr (wb_addr),
    .wb_data (wb_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pcanon_stack #(.MAX_DEPTH(MAX_DEPTH), .DW(AW)) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .push_data (cstart_nxt),
    .count     (cnt),
    .top       (stk_top)
  );

  always_comb begin
    wp_nxt     = wp_r;
    cstart_nxt = cstart_r;
    clen_nxt   = clen_r;
    dots_nxt   = dots_r;
    ovf_nxt    = ovf_r;
    fin_nxt    = fin_r;
    cnt_nxt    = cnt;
    op         = '0;
    wa_en      = 1'b0;
    wa_addr    = wp_r[AW-1:0];
    wa_data    = sep_r;
    wb_en      = 1'b0;
    wb_addr    = AW'(wp_r + LW'(1));
    wb_data    = in_data_byte;
    rd_en      = 1'b0;
    rd_addr    = AW'(in_read_index);
    rsel       = RSEL_ZERO;
    close_now  = 1'b0;
    end_now    = 1'b0;

    if (in_acc) begin
      case (in_mode)
        MODE_BYTE: begin
          if (fin_r) begin
            wp_nxt   = '0;
            clen_nxt = '0;
            dots_nxt = 1'b1;
            cnt_nxt  = '0;
            ovf_nxt  = 1'b0;
            fin_nxt  = 1'b0;
            op.clear = 1'b1;
          end
          if (!ovf_nxt) begin
            if (in_data_byte == sep_r) begin
              close_now = 1'b1;
            end else if (clen_nxt == 2'd0) begin
              if (({1'b0, wp_nxt} + (LW+1)'(2)) > (LW+1)'(MAX_LEN)) begin
                ovf_nxt = 1'b1;
              end else begin
                cstart_nxt = wp_nxt[AW-1:0];
                wa_en      = 1'b1;
                wa_addr    = wp_nxt[AW-1:0];
                wa_data    = sep_r;
                wb_en      = 1'b1;
                wb_addr    = AW'(wp_nxt + LW'(1));
                wp_nxt     = wp_nxt + LW'(2);
              end
            end else begin
              if (wp_nxt >= LW'(MAX_LEN)) begin
                ovf_nxt = 1'b1;
              end else begin
                wa_en   = 1'b1;
                wa_addr = wp_nxt[AW-1:0];
                wa_data = in_data_byte;
                wp_nxt  = wp_nxt + LW'(1);
              end
            end
            if (!close_now && !ovf_nxt) begin
              clen_nxt = (clen_nxt == 2'd3) ? 2'd3 : clen_nxt + 2'd1;
              dots_nxt = dots_nxt && (in_data_byte == DOT_BYTE);
            end
          end
        end
        MODE_END: begin
          if (!fin_r) begin
            close_now = !ovf_r;
            end_now   = !ovf_r;
            fin_nxt   = 1'b1;
          end
        end
        MODE_READ: begin
          rd_en = 1'b1;
          if ((XW'(in_read_index) < XW'(wp_r)) &&
              (XW'(in_read_index) < XW'(MAX_LEN))) begin
            rsel = RSEL_MEM;
          end else if ((wp_r == '0) && (in_read_index == '0)) begin
            rsel = RSEL_SEP;
          end
        end
        default: begin
        end
      endcase
    end

    if (close_now) begin
      if (clen_nxt == 2'd0) begin
      end else if (dots_nxt && (clen_nxt != 2'd3)) begin
        wp_nxt = LW'(cstart_nxt);
        if ((clen_nxt == 2'd2) && (cnt_nxt != '0)) begin
          op.pop  = 1'b1;
          cnt_nxt = cnt_nxt - CW'(1);
          wp_nxt  = LW'(stk_top);
        end
      end else if (cnt_nxt >= CW'(MAX_DEPTH)) begin
        ovf_nxt = 1'b1;
      end else begin
        op.push = 1'b1;
        cnt_nxt = cnt_nxt + CW'(1);
      end
      clen_nxt = '0;
      dots_nxt = 1'b1;
    end

    if (end_now && !ovf_nxt && (cnt_nxt == '0)) begin
      wa_en   = 1'b1;
      wa_addr = '0;
      wa_data = sep_r;
      wp_nxt  = LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r    <= SEP_RESET;
      wp_r     <= '0;
      cstart_r <= '0;
      clen_r   <= '0;
      dots_r   <= 1'b1;
      ovf_r    <= 1'b0;
      fin_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sep_r <= cfg_wr_data;
      end
      wp_r     <= wp_nxt;
      cstart_r <= cstart_nxt;
      clen_r   <= clen_nxt;
      dots_r   <= dots_nxt;
      ovf_r    <= ovf_nxt;
      fin_r    <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        v1_r <= 1'b1;
      end else if (adv1) begin
        v1_r <= 1'b0;
      end
      if (adv1) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sel1_r <= rsel;
      sep1_r <= sep_r;
      len1_r <= RLEN_W'(wp_nxt);
      dep1_r <= DEPTH_W'(cnt_nxt);
      ovf1_r <= ovf_nxt;
    end
    if (adv1) begin
      case (sel1_r)
        RSEL_MEM: byte_r <= rd_data;
        RSEL_SEP: byte_r <= sep1_r;
        default:  byte_r <= '0;
      endcase
      len_r   <= len1_r;
      dep_r   <= dep1_r;
      oflag_r <= ovf1_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_byte   = byte_r;
  assign out_result_length = len_r;
  assign out_kept_depth    = dep_r;
  assign out_overflow      = oflag_r;

endmodule

>>> sv/pcanon_checker.sv
module pcanon_checker #(
  parameter int MAX_DEPTH = 64
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [pcanon_pkg::BYTE_W-1:0]   out_result_byte,
  input logic [pcanon_pkg::RLEN_W-1:0]   out_result_length,
  input logic [pcanon_pkg::DEPTH_W-1:0]  out_kept_depth
);
  import pcanon_pkg::*;

  // an accepted request always has a result waiting at the output once it has passed stage 1
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ##1 out_valid)
    else $error("request produced no result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result_byte)))
    else $error("stalled result changed");

  a_empty_no_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_length == '0)) |-> (out_kept_depth == '0))
    else $error("components kept with empty path");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({4'b0, out_kept_depth} <= 11'(MAX_DEPTH)))
    else $error("kept depth beyond stack size");

endmodule

bind path_canonicalizer_unit pcanon_checker #(.MAX_DEPTH(MAX_DEPTH)) u_pcanon_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_result_byte   (out_result_byte),
  .out_result_length (out_result_length),
  .out_kept_depth    (out_kept_depth)
);
